/* rtl/ifcd_pkg.sv */
// Package for the IMU frame CRC deframer: frame layout constants,
// result codes and the byte-wide CRC-16/MODBUS update.
// No dependencies.
package ifcd_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN  = 26;
    localparam int unsigned CRC_SPAN   = 24;
    localparam int unsigned SAMPLE_CNT = 9;
    localparam int unsigned POS_W      = 5;

    localparam logic [POS_W-1:0] POS_IDLE    = POS_W'(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(CRC_SPAN);
    localparam logic [POS_W-1:0] POS_HDR0    = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1    = 5'd1;
    localparam logic [POS_W-1:0] POS_HDR2    = 5'd2;
    localparam logic [POS_W-1:0] POS_STATUS  = 5'd9;

    // Position of the low byte of each sample (gyro, accel, magnet; x, y, z)
    localparam logic [POS_W-1:0] SLOT_LO_POS [SAMPLE_CNT] = '{
        5'd3, 5'd5, 5'd7, 5'd10, 5'd12, 5'd14, 5'd17, 5'd19, 5'd21
    };

    // Header bytes
    localparam logic [7:0] HDR_BYTE0 = 8'h47; // 'G'
    localparam logic [7:0] HDR_BYTE1 = 8'h59; // 'Y'
    localparam logic [7:0] HDR_BYTE2 = 8'h52; // 'R'

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Result codes
    typedef enum logic [1:0] {
        FR_GOOD    = 2'd0,
        FR_CRC_BAD = 2'd1,
        FR_HDR_BAD = 2'd2
    } t_frame_result;

    // One byte of the reflected CRC, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/imu_frame_crc_deframer.sv */
// IMU frame deframer: byte-serial CRC-16/MODBUS check, header check and
// sample unpacking of a 26-byte frame, with a registered result.
// Depends on ifcd_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_rx_byte, i_frame_start
//  out     | output    | o_out_valid / i_out_ready | o_frame_result, samples, status,
//          |           |                           | o_crc_fail_total
//
// One byte is taken per cycle; the CRC update of a byte is done in the cycle
// it is accepted. The result of a frame appears in the output register in the
// cycle after its last byte (byte 25) is accepted. Input stalls only while
// a result waits in that register and the sink holds i_out_ready low. Reset
// (synchronous, active low) leaves the block idle until a byte with
// i_frame_start, and clears the CRC failure count.
module imu_frame_crc_deframer
    import ifcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_frame_start,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_frame_result,
    output logic signed [15:0] o_gyro_x,
    output logic signed [15:0] o_gyro_y,
    output logic signed [15:0] o_gyro_z,
    output logic signed [15:0] o_accel_x,
    output logic signed [15:0] o_accel_y,
    output logic signed [15:0] o_accel_z,
    output logic signed [15:0] o_magnet_x,
    output logic signed [15:0] o_magnet_y,
    output logic signed [15:0] o_magnet_z,
    output logic [7:0]         o_gyro_status,
    output logic [31:0]        o_crc_fail_total
);

    // Frame state
    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic             r_hdr_ok, n_hdr_ok;
    logic [7:0]       r_status;
    logic [7:0]       r_crc_lo;
    logic [15:0]      r_sample [SAMPLE_CNT];
    logic [31:0]      r_fail_cnt, n_fail_cnt;

    // Result register
    logic             r_out_valid, n_out_valid;
    t_frame_result    r_out_code, n_out_code;
    logic [15:0]      r_out_sample [SAMPLE_CNT];
    logic [7:0]       r_out_status;

    logic             in_xfer;
    logic             out_xfer;
    logic [POS_W-1:0] pos_eff;
    logic [15:0]      crc_base;
    logic             hdr_base;
    logic             active;
    logic             last_byte;
    logic             crc_ok;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;

    // A start byte restarts position, CRC and header check
    assign pos_eff   = i_frame_start ? POS_HDR0 : r_pos;
    assign crc_base  = i_frame_start ? CRC_INIT : r_crc;
    assign hdr_base  = i_frame_start ? 1'b1 : r_hdr_ok;
    assign active    = in_xfer && (pos_eff < POS_IDLE);
    assign last_byte = active && (pos_eff == POS_LAST);
    assign crc_ok    = (r_crc[7:0] == r_crc_lo) && (r_crc[15:8] == i_rx_byte);

    // Frame control and CRC
    always_comb begin
        n_pos      = r_pos;
        n_crc      = r_crc;
        n_hdr_ok   = r_hdr_ok;
        n_fail_cnt = r_fail_cnt;
        if (active) begin
            n_crc    = crc_base;
            n_hdr_ok = hdr_base;
            n_pos    = last_byte ? POS_IDLE : pos_eff + 1'b1;
            if (pos_eff < POS_CRC_LO) begin
                n_crc = crc_byte(crc_base, i_rx_byte);
            end
            if ((pos_eff == POS_HDR0 && i_rx_byte != HDR_BYTE0) ||
                (pos_eff == POS_HDR1 && i_rx_byte != HDR_BYTE1) ||
                (pos_eff == POS_HDR2 && i_rx_byte != HDR_BYTE2)) begin
                n_hdr_ok = 1'b0;
            end
            if (last_byte && !crc_ok) begin
                n_fail_cnt = r_fail_cnt + 32'd1;
            end
        end
    end

    // Result code and output valid
    always_comb begin
        n_out_valid = r_out_valid && !out_xfer;
        n_out_code  = r_out_code;
        if (last_byte) begin
            n_out_valid = 1'b1;
            if (!crc_ok) begin
                n_out_code = FR_CRC_BAD;
            end else if (!r_hdr_ok) begin
                n_out_code = FR_HDR_BAD;
            end else begin
                n_out_code = FR_GOOD;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_IDLE;
            r_crc       <= CRC_INIT;
            r_hdr_ok    <= 1'b1;
            r_fail_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_out_code  <= FR_GOOD;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_hdr_ok    <= n_hdr_ok;
            r_fail_cnt  <= n_fail_cnt;
            r_out_valid <= n_out_valid;
            r_out_code  <= n_out_code;
        end
    end

    // Payload capture: status, CRC low byte, sample bytes
    always_ff @(posedge i_clk) begin
        if (active && pos_eff == POS_STATUS) begin
            r_status <= i_rx_byte;
        end
        if (active && pos_eff == POS_CRC_LO) begin
            r_crc_lo <= i_rx_byte;
        end
        for (int s = 0; s < SAMPLE_CNT; s++) begin
            if (active && pos_eff == SLOT_LO_POS[s]) begin
                r_sample[s][7:0] <= i_rx_byte;
            end
            if (active && pos_eff == SLOT_LO_POS[s] + 1'b1) begin
                r_sample[s][15:8] <= i_rx_byte;
            end
        end
    end

    // Result payload; bad frames report zero samples and status
    always_ff @(posedge i_clk) begin
        if (last_byte) begin
            for (int s = 0; s < SAMPLE_CNT; s++) begin
                r_out_sample[s] <= (n_out_code == FR_GOOD) ? r_sample[s] : 16'h0000;
            end
            r_out_status <= (n_out_code == FR_GOOD) ? r_status : 8'h00;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_frame_result   = r_out_code;
    assign o_gyro_x         = $signed(r_out_sample[0]);
    assign o_gyro_y         = $signed(r_out_sample[1]);
    assign o_gyro_z         = $signed(r_out_sample[2]);
    assign o_accel_x        = $signed(r_out_sample[3]);
    assign o_accel_y        = $signed(r_out_sample[4]);
    assign o_accel_z        = $signed(r_out_sample[5]);
    assign o_magnet_x       = $signed(r_out_sample[6]);
    assign o_magnet_y       = $signed(r_out_sample[7]);
    assign o_magnet_z       = $signed(r_out_sample[8]);
    assign o_gyro_status    = r_out_status;
    assign o_crc_fail_total = r_fail_cnt;

    // Checks
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_last_byte_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_byte |=> r_out_valid)
        else $error("last byte of frame gave no result");

    a_bad_frame_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_code != FR_GOOD) |->
            (r_out_sample[0] == 16'h0000 && r_out_status == 8'h00))
        else $error("bad frame carries sample data");

    a_fail_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !last_byte |=> r_fail_cnt == $past(r_fail_cnt))
        else $error("CRC failure count moved without a frame end");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_IDLE)
        else $error("byte position out of range");

endmodule
